/* hw/rtl/bbf_pkg.sv */
// shared types and constants for the rgb box blur filter
`default_nettype none
package bbf_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int RADIUS_REG_W = 3;
  localparam int ROW_W        = 12;
  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;

  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [RADIUS_REG_W-1:0] RESET_RADIUS = 3'd2;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

  typedef struct packed {
    logic take;
    logic ls_write;
    logic cnt_clr;
    logic cs_step;
    logic cs_store;
    logic ws_step;
    logic div_start;
    logic pass_read;
    logic load_blur;
    logic load_pass;
    logic out_done;
  } cmd_t;

  typedef struct packed {
    logic flush;
    logic done;
    logic need_csum;
    logic lag_ok;
    logic lag_ok_q;
    logic interior;
    logic cnt_last;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/bbf_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module bbf_div #(
  parameter int DVW = 16,
  parameter int DSW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic      [DVW-1:0] quotient,
  output logic                done
);
  localparam int CTW = $clog2(DVW + 1);

  logic           busy;
  logic [CTW-1:0] cnt;
  logic [DSW-1:0] rem;
  logic [DVW-1:0] quo;
  logic [DSW:0]   rem_t;
  logic [DSW:0]   diff;
  logic           fits;

  assign rem_t = {rem, quo[DVW-1]};
  assign diff  = rem_t - {1'b0, divisor};
  assign fits  = rem_t >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CTW'(DVW);
    end else if (busy) begin
      cnt <= cnt - CTW'(1);
      if (cnt == CTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DVW-2:0], fits};
      rem <= fits ? diff[DSW-1:0] : rem_t[DSW-1:0];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/bbf_datapath.sv */
// line store, column sums, counters, config registers and output registers
`default_nettype none
module bbf_datapath #(
  parameter int MAX_WIDTH  = bbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = bbf_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bbf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           kind,
  input  wire logic [bbf_pkg::CH_W-1:0]       blue,
  input  wire logic [bbf_pkg::CH_W-1:0]       green,
  input  wire logic [bbf_pkg::CH_W-1:0]       red,
  output logic      [bbf_pkg::CH_W-1:0]       out_blue,
  output logic      [bbf_pkg::CH_W-1:0]       out_green,
  output logic      [bbf_pkg::CH_W-1:0]       out_red,
  output logic                                frame_end,
  input  wire bbf_pkg::cmd_t                  cmd,
  output bbf_pkg::sts_t                       sts
);
  localparam int SLOTS = 2 * MAX_RADIUS + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int XW    = WW + 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DW    = $clog2(SLOTS + 1);
  localparam int SW    = $clog2(SLOTS);
  localparam int LSD   = MAX_WIDTH * SLOTS;
  localparam int LAW   = $clog2(LSD);
  localparam int CSW   = $clog2(SLOTS * 255 + 1);
  localparam int WSW   = $clog2(SLOTS * SLOTS * 255 + 1);
  localparam int DDW   = $clog2(SLOTS * SLOTS + 1);
  localparam int HW    = bbf_pkg::HEIGHT_REG_W;
  localparam int RWW   = bbf_pkg::ROW_W;
  localparam int NW    = RWW + WW + 1;

  logic [bbf_pkg::WIDTH_REG_W-1:0]  cfg_w;
  logic [bbf_pkg::HEIGHT_REG_W-1:0] cfg_h;
  logic [bbf_pkg::RADIUS_REG_W-1:0] cfg_r;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RW-1:0]  r_eff;
  logic [DW-1:0]  d_val;
  logic [DDW-1:0] dd;

  logic [CW-1:0]  in_col;
  logic [RWW-1:0] in_row;
  logic [SW-1:0]  in_slot;
  logic           done;
  logic [CW-1:0]  out_x;
  logic [RWW-1:0] out_y;
  logic [SW-1:0]  out_slot;
  logic [CW-1:0]  cur_col;
  logic           lag_ok_q;
  logic           kind_q;
  logic [bbf_pkg::PIX_W-1:0] pix_q;
  logic [NW-1:0]  in_pos;
  logic [NW-1:0]  lag_pos;

  logic [DW-1:0]  cnt;
  logic [WSW-1:0] acc [3];

  logic [bbf_pkg::PIX_W-1:0] ls_mem [LSD];
  logic [bbf_pkg::PIX_W-1:0] ls_rdata;
  logic [3*CSW-1:0]          col_mem [MAX_WIDTH];
  logic [3*CSW-1:0]          col_rdata;
  logic [LAW-1:0] ls_wa;
  logic [LAW-1:0] ls_ra;
  logic [CW-1:0]  col_ra;
  logic           ls_re;
  logic           col_re;

  logic col_last, row_last, x_last, y_last, slot_wrap_in, slot_wrap_out;
  logic need_csum, lag_ok, interior, cnt_last, last_out;

  logic [WSW-1:0] quo [3];
  logic [2:0]     div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= bbf_pkg::RESET_WIDTH;
      cfg_h <= bbf_pkg::RESET_HEIGHT;
      cfg_r <= bbf_pkg::RESET_RADIUS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bbf_pkg::CFG_FRAME_WIDTH:  cfg_w <= cfg_data[bbf_pkg::WIDTH_REG_W-1:0];
        bbf_pkg::CFG_FRAME_HEIGHT: cfg_h <= cfg_data[bbf_pkg::HEIGHT_REG_W-1:0];
        bbf_pkg::CFG_RADIUS:       cfg_r <= cfg_data[bbf_pkg::RADIUS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w == '0) w_eff = WW'(1);
    else if (32'(cfg_w) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_w);
    if (cfg_h == '0) h_eff = HW'(1);
    else if (cfg_h > bbf_pkg::HEIGHT_LIMIT) h_eff = bbf_pkg::HEIGHT_LIMIT;
    else h_eff = cfg_h;
    if (32'(cfg_r) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(cfg_r);
  end

  assign d_val = DW'({r_eff, 1'b1});
  assign dd    = DDW'(d_val) * DDW'(d_val);

  assign in_pos  = NW'(in_row) * NW'(w_eff) + NW'(in_col);
  assign lag_pos = NW'(r_eff) * NW'(w_eff) + NW'(r_eff);

  assign col_last      = (XW'(in_col) + XW'(1)) >= XW'(w_eff);
  assign row_last      = (HW'(in_row) + HW'(1)) >= h_eff;
  assign x_last        = (XW'(out_x) + XW'(1)) >= XW'(w_eff);
  assign y_last        = (HW'(out_y) + HW'(1)) >= h_eff;
  assign slot_wrap_in  = in_slot == SW'(d_val - DW'(1));
  assign slot_wrap_out = out_slot == SW'(d_val - DW'(1));
  assign need_csum     = HW'(in_row) >= HW'({r_eff, 1'b0});
  assign lag_ok        = in_pos >= lag_pos;
  assign interior      = (HW'(out_y) >= HW'(r_eff)) &&
                         ((HW'(out_y) + HW'(r_eff)) < h_eff) &&
                         (XW'(out_x) >= XW'(r_eff)) &&
                         ((XW'(out_x) + XW'(r_eff)) < XW'(w_eff));
  assign cnt_last      = cnt == d_val;
  assign last_out      = x_last && y_last;
  assign frame_end     = last_out;

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en || (cmd.out_done && last_out)) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      done     <= 1'b0;
      out_x    <= '0;
      out_y    <= '0;
      out_slot <= '0;
    end else begin
      if (cmd.ls_write) begin
        if (col_last) begin
          in_col <= '0;
          if (row_last) begin
            done <= 1'b1;
          end else begin
            in_row  <= in_row + RWW'(1);
            in_slot <= slot_wrap_in ? '0 : in_slot + SW'(1);
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (cmd.out_done) begin
        if (x_last) begin
          out_x    <= '0;
          out_y    <= out_y + RWW'(1);
          out_slot <= slot_wrap_out ? '0 : out_slot + SW'(1);
        end else begin
          out_x <= out_x + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_q <= kind;
      pix_q  <= {red, green, blue};
    end
    if (cmd.ls_write) begin
      cur_col  <= in_col;
      lag_ok_q <= lag_ok;
    end
  end

  // memory addressing
  assign ls_wa  = LAW'(in_slot) * LAW'(MAX_WIDTH) + LAW'(in_col);
  assign ls_ra  = cmd.pass_read ? LAW'(out_slot) * LAW'(MAX_WIDTH) + LAW'(out_x)
                                : LAW'(SW'(cnt)) * LAW'(MAX_WIDTH) + LAW'(cur_col);
  assign ls_re  = (cmd.cs_step && !cnt_last) || cmd.pass_read;
  assign col_ra = CW'(XW'(out_x) - XW'(r_eff) + XW'(cnt));
  assign col_re = cmd.ws_step && !cnt_last;

  always_ff @(posedge clk) begin
    if (cmd.ls_write) ls_mem[ls_wa] <= pix_q;
    if (ls_re) ls_rdata <= ls_mem[ls_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.cs_store) begin
      col_mem[cur_col] <= {CSW'(acc[2]), CSW'(acc[1]), CSW'(acc[0])};
    end
    if (col_re) col_rdata <= col_mem[col_ra];
  end

  // step counter and running sums
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt <= '0;
      for (int c = 0; c < 3; c++) acc[c] <= '0;
    end else if (cmd.cs_step || cmd.ws_step) begin
      cnt <= cnt + DW'(1);
      if (cnt != '0) begin
        for (int c = 0; c < 3; c++) begin
          if (cmd.cs_step) acc[c] <= acc[c] + WSW'(ls_rdata[c*bbf_pkg::CH_W +: bbf_pkg::CH_W]);
          else acc[c] <= acc[c] + WSW'(col_rdata[c*CSW +: CSW]);
        end
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    bbf_div #(.DVW(WSW), .DSW(DDW)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_start),
      .dividend (acc[g]),
      .divisor  (dd),
      .quotient (quo[g]),
      .done     (div_done[g])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.load_blur) begin
      out_blue  <= quo[0][bbf_pkg::CH_W-1:0];
      out_green <= quo[1][bbf_pkg::CH_W-1:0];
      out_red   <= quo[2][bbf_pkg::CH_W-1:0];
    end else if (cmd.load_pass) begin
      out_blue  <= ls_rdata[7:0];
      out_green <= ls_rdata[15:8];
      out_red   <= ls_rdata[23:16];
    end
  end

  always_comb begin
    sts.flush     = kind_q || done;
    sts.done      = done;
    sts.need_csum = need_csum;
    sts.lag_ok    = lag_ok;
    sts.lag_ok_q  = lag_ok_q;
    sts.interior  = interior;
    sts.cnt_last  = cnt_last;
    sts.div_done  = &div_done;
  end
endmodule
`default_nettype wire

/* hw/rtl/bbf_ctrl.sv */
// controller state machine sequencing one beat at a time
`default_nettype none
module bbf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire bbf_pkg::sts_t sts,
  output bbf_pkg::cmd_t      cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_WR   = 4'd2;
  localparam logic [3:0] S_CS   = 4'd3;
  localparam logic [3:0] S_CSST = 4'd4;
  localparam logic [3:0] S_EMIT = 4'd5;
  localparam logic [3:0] S_WS   = 4'd6;
  localparam logic [3:0] S_DIVS = 4'd7;
  localparam logic [3:0] S_DIVW = 4'd8;
  localparam logic [3:0] S_PRD  = 4'd9;
  localparam logic [3:0] S_PCAP = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = S_DEC;
      end
      S_DEC: begin
        if (sts.flush) state_next = sts.done ? S_EMIT : S_IDLE;
        else state_next = S_WR;
      end
      S_WR: begin
        cmd.ls_write = 1'b1;
        cmd.cnt_clr  = 1'b1;
        if (sts.need_csum) state_next = S_CS;
        else state_next = sts.lag_ok ? S_EMIT : S_IDLE;
      end
      S_CS: begin
        cmd.cs_step = 1'b1;
        if (sts.cnt_last) state_next = S_CSST;
      end
      S_CSST: begin
        cmd.cs_store = 1'b1;
        state_next = sts.lag_ok_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.cnt_clr = 1'b1;
        state_next = sts.interior ? S_WS : S_PRD;
      end
      S_WS: begin
        cmd.ws_step = 1'b1;
        if (sts.cnt_last) state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.load_blur = 1'b1;
          state_next = S_OUT;
        end
      end
      S_PRD: begin
        cmd.pass_read = 1'b1;
        state_next = S_PCAP;
      end
      S_PCAP: begin
        cmd.load_pass = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_done = out_ready;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

/* hw/rtl/rgb_box_blur_filter.sv */
// top level of the rgb box blur filter
`default_nettype none
// Streaming box blur of 8-bit BGR pixels in raster order. Positions whose
// (2r+1) square window fits inside the frame get the per-channel window mean,
// truncated; border positions pass the pixel through. Results trail the input
// by r rows plus r pixels; flush beats (kind=1) drain the tail of the frame and
// frame_end marks its last result. Beats are handled one at a time: once 2r rows
// are stored, each pixel also rebuilds its column sum over the single read port
// of the line store. A result is read back from the line store at the border, or
// formed inside by a walk over the stored column sums and a bit-serial divider
// whose quotient is 16 bits wide at the default radius limit. Any register write
// restarts the frame.
module rgb_box_blur_filter #(
  parameter int MAX_WIDTH  = bbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = bbf_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bbf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           kind,
  input  wire logic [bbf_pkg::CH_W-1:0]       blue,
  input  wire logic [bbf_pkg::CH_W-1:0]       green,
  input  wire logic [bbf_pkg::CH_W-1:0]       red,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [bbf_pkg::CH_W-1:0]       out_blue,
  output logic      [bbf_pkg::CH_W-1:0]       out_green,
  output logic      [bbf_pkg::CH_W-1:0]       out_red,
  output logic                                frame_end
);
  bbf_pkg::cmd_t cmd;
  bbf_pkg::sts_t sts;

  bbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbf_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .frame_end (frame_end),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output open together");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken while busy");

  a_result_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("not idle after result");
endmodule
`default_nettype wire
